FILE: hdl/newton_poly5_root_macros.svh
// Assertion macros shared by the Newton root finder RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef NEWTON_POLY5_ROOT_MACROS_SVH
`define NEWTON_POLY5_ROOT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define NP5_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NP5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/np5_pkg.sv
// Package for the Newton root finder: widths, codes, handshake structs, saturation.
// Used by np5_mul, np5_div and newton_poly5_root.
package np5_pkg;

    localparam int W         = 48;          // Q16.32 word
    localparam int FRAC      = 32;
    localparam int QINT      = W - 1 - FRAC; // integer bits of a quotient magnitude
    localparam int NCOEF     = 6;
    localparam int TOL_W     = 32;
    localparam int STEPS_W   = 10;
    localparam int MAX_ITER  = 1000;
    localparam int ITER_W    = $clog2(MAX_ITER + 1);
    localparam int DIGIT_W   = 16;
    localparam int N_DIGITS  = W / DIGIT_W;
    localparam int IDX_W     = $clog2(NCOEF);
    localparam int CFG_IDX_W = 3;
    localparam int XW        = W + 3;       // wide enough for 5 * a and sums

    typedef logic signed [W-1:0] q_t;

    localparam q_t QMAX = {1'b0, {(W-1){1'b1}}};
    localparam q_t QMIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_TOL = CFG_IDX_W'(NCOEF);

    typedef enum logic [1:0] {
        STATUS_CONVERGED  = 2'd0,
        STATUS_FAILED     = 2'd1,
        STATUS_INCOMPLETE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ITER,
        ST_FMUL,
        ST_FWAIT,
        ST_DMUL,
        ST_DWAIT,
        ST_CHECK,
        ST_DIV,
        ST_DIVWAIT,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic start;
        q_t   a;
        q_t   b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        q_t   prod;
        logic ov;
    } mul_rsp_t;

    typedef struct packed {
        logic start;
        q_t   num;
        q_t   den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        q_t             quo;
        logic [W-2:0]   qmag;
        logic           ov;
    } div_rsp_t;

    typedef struct packed {
        q_t   val;
        logic ov;
    } sat_t;

    function automatic logic signed [XW-1:0] ext(input q_t v);
        ext = {{(XW-W){v[W-1]}}, v};
    endfunction

    // clamp to [-2^47, 2^47-1]; overflow when the top bits disagree
    function automatic sat_t sat_wide(input logic signed [XW-1:0] v);
        sat_t s;
        s.ov  = (v[XW-1:W-1] != {(XW-W+1){1'b0}}) && (v[XW-1:W-1] != {(XW-W+1){1'b1}});
        s.val = s.ov ? (v[XW-1] ? QMIN : QMAX) : v[W-1:0];
        return s;
    endfunction

endpackage

FILE: hdl/np5_mul.sv
// Sequential Q16.32 multiplier, one 48x16 partial product per cycle, saturating.
// Depends on np5_pkg.
module np5_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  np5_pkg::mul_req_t req,
    output np5_pkg::mul_rsp_t rsp
);
    import np5_pkg::*;

    localparam int CNT_W = $clog2(N_DIGITS + 1);
    localparam int RW    = 2 * W - FRAC;
    localparam logic [RW-1:0] R_NEG_MAX = {{(RW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [RW-1:0] R_POS_MAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};

    logic [W-1:0]         ua_reg, ub_reg;
    logic                 neg_reg;
    logic [2*W-1:0]       acc_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg;
    q_t                   prod_reg, prod_next;
    logic                 ov_reg, ov_next;

    logic [W-1:0]         ua_in, ub_in;
    logic [W+DIGIT_W-1:0] pp;
    logic [2*W-1:0]       acc_sum;
    logic [RW-1:0]        r;

    always_comb
    begin
        ua_in   = req.a[W-1] ? W'(-req.a) : W'(req.a);
        ub_in   = req.b[W-1] ? W'(-req.b) : W'(req.b);
        pp      = ua_reg * ub_reg[W-1 -: DIGIT_W];
        acc_sum = {acc_reg[2*W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + (2*W)'(pp);
        r       = acc_reg[2*W-1:FRAC];
        ov_next = 1'b0;
        if (neg_reg)
        begin
            if (r > R_NEG_MAX)
            begin
                ov_next   = 1'b1;
                prod_next = QMIN;
            end
            else
            begin
                prod_next = -q_t'(r[W-1:0]);
            end
        end
        else if (r > R_POS_MAX)
        begin
            ov_next   = 1'b1;
            prod_next = QMAX;
        end
        else
        begin
            prod_next = q_t'(r[W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(N_DIGITS))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ua_reg  <= ua_in;
            ub_reg  <= ub_in;
            neg_reg <= req.a[W-1] ^ req.b[W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(N_DIGITS))
            begin
                prod_reg <= prod_next;
                ov_reg   <= ov_next;
            end
            else
            begin
                acc_reg <= acc_sum;
                ub_reg  <= {ub_reg[W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;
    assign rsp.ov   = ov_reg;

endmodule

FILE: hdl/np5_div.sv
// Restoring Q16.32 divider, one quotient bit per cycle, flags quotients of 2^47 or more.
// Depends on np5_pkg.
module np5_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  np5_pkg::div_req_t req,
    output np5_pkg::div_rsp_t rsp
);
    import np5_pkg::*;

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     un_reg, ud_reg, rem_reg;
    logic [W-2:0]     nb_reg, q_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             chk_reg, busy_reg, done_reg, ov_reg;
    q_t               quo_reg;

    logic [W:0]       t;
    logic             ge;
    logic             too_big;

    always_comb
    begin
        t       = {rem_reg, nb_reg[W-2]};
        ge      = t >= {1'b0, ud_reg};
        too_big = {{QINT{1'b0}}, un_reg} >= {ud_reg, {QINT{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            chk_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (chk_reg)
        begin
            chk_reg  <= 1'b0;
            busy_reg <= !too_big;
            done_reg <= too_big;
            cnt_reg  <= CNT_W'(W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            un_reg  <= req.num[W-1] ? W'(-req.num) : W'(req.num);
            ud_reg  <= req.den[W-1] ? W'(-req.den) : W'(req.den);
            neg_reg <= req.num[W-1] ^ req.den[W-1];
        end
        else if (chk_reg)
        begin
            ov_reg  <= too_big;
            rem_reg <= un_reg >> QINT;
            nb_reg  <= {un_reg[QINT-1:0], {FRAC{1'b0}}};
            q_reg   <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                quo_reg <= neg_reg ? -q_t'({1'b0, q_reg}) : q_t'({1'b0, q_reg});
            end
            else
            begin
                rem_reg <= ge ? W'(t - {1'b0, ud_reg}) : W'(t);
                q_reg   <= {q_reg[W-3:0], ge};
                nb_reg  <= {nb_reg[W-3:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.qmag = q_reg;
    assign rsp.ov   = ov_reg;

endmodule

FILE: hdl/newton_poly5_root.sv
// Top level of the fixed-point Newton-Raphson root finder for a quintic.
// Depends on np5_pkg, np5_mul, np5_div and newton_poly5_root_macros.svh.

// Each start point sent on the s_ stream runs Newton iterations on
// f(x) = a0 + a1 x + ... + a5 x^5 (Q16.32, saturating) and yields one result
// on the m_ stream. One item is worked at a time; s_tready is high only when
// the sequencer is idle. A full iteration runs nine 48x48 products on the
// shared multiplier (each a start, three 48x16 partial products, a saturate
// step and the done step), one pass of the one-bit-per-cycle divider (range
// check, quotient bits, signed result and done) and the sequencing states.
// An item runs at most 1000 iterations; convergence, a zero derivative or
// overflow ends it sooner. A finished result waits in the output register
// while the next start point is taken. Coefficients and tolerance sit on the
// APB port at 8*i.

`include "newton_poly5_root_macros.svh"

module newton_poly5_root
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // start point stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [47:0] start_x
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [47:0] root_estimate, [57:48] steps_used, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import np5_pkg::*;

    st_t                          state_reg, state_next;

    logic [NCOEF-1:0][W-1:0]      coef_reg;
    logic [TOL_W-1:0]             tol_reg;

    q_t                           x_reg, f_reg, fd_reg;
    logic                         ov_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [ITER_W-1:0]            iter_reg;
    logic [STEPS_W-1:0]           steps_reg;
    q_t                           res_x_reg;
    status_t                      res_status_reg;

    logic                         out_valid_reg;
    q_t                           out_root_reg;
    status_t                      out_status_reg;
    logic [STEPS_W-1:0]           out_steps_reg;

    mul_req_t                     mul_req;
    mul_rsp_t                     mul_rsp;
    div_req_t                     div_req;
    div_rsp_t                     div_rsp;

    logic                         cfg_wr;
    logic [CFG_IDX_W-1:0]         cfg_idx;
    logic                         in_xfer;
    logic                         out_load;

    q_t                           a_cur;
    sat_t                         scaled_cur, scaled_top, f_sum, fd_sum, nx_sat;
    logic                         conv;
    logic                         fail_chk;

    np5_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    np5_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == REG_TOL)
        begin
            prdata = 64'(tol_reg);
        end
        else if (cfg_idx < REG_TOL)
        begin
            prdata = 64'(coef_reg[cfg_idx[IDX_W-1:0]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            tol_reg  <= TOL_W'(4295);
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == REG_TOL)
            begin
                tol_reg <= pwdata[TOL_W-1:0];
            end
            else if (cfg_idx < REG_TOL)
            begin
                coef_reg[cfg_idx[IDX_W-1:0]] <= pwdata[W-1:0];
            end
        end
    end

    // ------------------------------------------------------- datapath glue
    always_comb
    begin
        a_cur      = coef_reg[idx_reg];
        // i * a_i for the derivative, and 5 * a5 to seed it
        scaled_cur = sat_wide(ext(a_cur) * $signed({{(XW-IDX_W){1'b0}}, idx_reg}));
        scaled_top = sat_wide(ext(coef_reg[NCOEF-1]) * $signed(XW'(NCOEF - 1)));
        f_sum      = sat_wide(ext(mul_rsp.prod) + ext(a_cur));
        fd_sum     = sat_wide(ext(mul_rsp.prod) + ext(scaled_cur.val));
        nx_sat     = sat_wide(ext(x_reg) - ext(div_rsp.quo));
        conv       = div_rsp.qmag < (W-1)'(tol_reg);
        fail_chk   = (fd_reg == '0) || ov_reg;
    end

    // ------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER:    state_next = ST_FMUL;
            ST_FMUL:    state_next = ST_FWAIT;
            ST_FWAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = (idx_reg == '0) ? ST_CHECK : ST_DMUL;
                end
            end
            ST_DMUL:    state_next = ST_DWAIT;
            ST_DWAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_FMUL;
                end
            end
            ST_CHECK:   state_next = fail_chk ? ST_DONE : ST_DIV;
            ST_DIV:     state_next = ST_DIVWAIT;
            ST_DIVWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.ov || nx_sat.ov || conv
                        || iter_reg == ITER_W'(MAX_ITER))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ITER;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------- outputs
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        mul_req.start = (state_reg == ST_FMUL) || (state_reg == ST_DMUL);
        mul_req.a     = (state_reg == ST_DMUL) ? fd_reg : f_reg;
        mul_req.b     = x_reg;
        div_req.start = (state_reg == ST_DIV);
        div_req.num   = f_reg;
        div_req.den   = fd_reg;
        out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    assign in_xfer = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            steps_reg     <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        iter_reg  <= '0;
                        steps_reg <= '0;
                    end
                end
                ST_ITER:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (steps_reg != {STEPS_W{1'b1}})
                    begin
                        steps_reg <= steps_reg + 1'b1;
                    end
                    idx_reg <= IDX_W'(NCOEF - 2);
                end
                ST_DWAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    x_reg <= s_tdata;
                end
            end
            ST_ITER:
            begin
                f_reg  <= coef_reg[NCOEF-1];
                fd_reg <= scaled_top.val;
                ov_reg <= scaled_top.ov;
            end
            ST_FWAIT:
            begin
                if (mul_rsp.done)
                begin
                    f_reg  <= f_sum.val;
                    ov_reg <= ov_reg | mul_rsp.ov | f_sum.ov;
                end
            end
            ST_DWAIT:
            begin
                if (mul_rsp.done)
                begin
                    fd_reg <= fd_sum.val;
                    ov_reg <= ov_reg | mul_rsp.ov | scaled_cur.ov | fd_sum.ov;
                end
            end
            ST_CHECK:
            begin
                if (fail_chk)
                begin
                    res_x_reg      <= x_reg;
                    res_status_reg <= STATUS_FAILED;
                end
            end
            ST_DIVWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.ov || nx_sat.ov)
                    begin
                        res_x_reg      <= x_reg;
                        res_status_reg <= STATUS_FAILED;
                    end
                    else
                    begin
                        res_x_reg      <= nx_sat.val;
                        res_status_reg <= conv ? STATUS_CONVERGED : STATUS_INCOMPLETE;
                        x_reg          <= nx_sat.val;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_root_reg   <= res_x_reg;
                    out_status_reg <= res_status_reg;
                    out_steps_reg  <= steps_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(64-W-STEPS_W){1'b0}}, out_steps_reg, out_root_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------- assertions
    `NP5_ASSERT_NEXT(a_accept_starts, in_xfer, (state_reg == ST_ITER) && (steps_reg == '0),
        "accepted start point did not begin an iteration")
    `NP5_ASSERT_NOW(a_iter_bound, 1'b1, iter_reg <= ITER_W'(MAX_ITER),
        "iteration count ran past its limit")
    `NP5_ASSERT_NEXT(a_mul_latency, mul_req.start, !mul_rsp.done,
        "multiplier reported done straight after a start")
    `NP5_ASSERT_NOW(a_mul_idle_start, mul_req.start,
        (state_reg == ST_FMUL) || (state_reg == ST_DMUL),
        "multiplier started outside a multiply step")

endmodule

FILE: bench/tb_newton_poly5_root.sv
// Testbench for newton_poly5_root: directed and random start points under several
// coefficient and tolerance settings, each result checked against an in-bench predictor.
// Depends on np5_pkg and the newton_poly5_root RTL.
`timescale 1ns / 100ps

module tb_newton_poly5_root;
    import np5_pkg::*;

    localparam longint QHI        = 64'sh7FFF_FFFF_FFFF;
    localparam longint QLO        = -64'sh8000_0000_0000;
    localparam longint ONE        = 64'sh1_0000_0000;
    // room for items of up to 1000 iterations; ~120 items, with stalls
    localparam longint CYCLE_LIMIT = 64_000_000;

    typedef struct {
        q_t      root;
        status_t status;
        logic [STEPS_W-1:0] steps;
    } root_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [47:0] start_x
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [47:0] root_estimate, [57:48] steps_used
    logic [1:0]  m_tuser;   // [1:0] status

    newton_poly5_root dut (.*);

    // predictor's own copy of the register file
    longint       coef_shadow [NCOEF];
    longint       tol_shadow;

    logic [47:0]  start_points [$];   // waiting to be sent
    root_result_t roots_due [$];      // predicted, not yet seen
    bit           saw_error;
    bit           calm;               // no idling on either side
    bit           math_ov;            // overflow flag for the predictor arithmetic
    longint       cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Fixed-point predictor
    // ---------------------------------------------------------------------
    function automatic longint clamp48(input longint v);
        if (v > QHI)
        begin
            math_ov = 1'b1;
            return QHI;
        end
        if (v < QLO)
        begin
            math_ov = 1'b1;
            return QLO;
        end
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        logic [95:0] ua, ub, p;
        longint unsigned r;
        ua = a < 0 ? 96'(-a) : 96'(a);
        ub = b < 0 ? 96'(-b) : 96'(b);
        p  = ua * ub;
        r  = 64'(p >> FRAC);     // truncate magnitude
        if ((a < 0) != (b < 0))
        begin
            if (r > 64'h8000_0000_0000)
            begin
                math_ov = 1'b1;
                return QLO;
            end
            return -longint'(r);
        end
        if (r > 64'h7FFF_FFFF_FFFF)
        begin
            math_ov = 1'b1;
            return QHI;
        end
        return longint'(r);
    endfunction

    // divisor must be nonzero; quotient magnitude of 2^47 or more is an overflow
    function automatic longint fx_div(input longint n, input longint d);
        logic [95:0] un, ud, q;
        un = n < 0 ? 96'(-n) : 96'(n);
        ud = d < 0 ? 96'(-d) : 96'(d);
        if (un / ud >= 96'(1 << 15))
        begin
            math_ov = 1'b1;
            return 0;
        end
        q = (un << FRAC) / ud;
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic root_result_t solve_quintic(input logic [47:0] start);
        root_result_t res;
        longint x, f, fd, q, nx, qmag;
        int     k, i;
        x          = longint'($signed(start));
        res.root   = start;
        res.status = STATUS_INCOMPLETE;
        res.steps  = '0;
        for (k = 1; k <= MAX_ITER; k++)
        begin
            math_ov   = 1'b0;
            res.steps = STEPS_W'(k);
            f  = coef_shadow[5];
            fd = clamp48(5 * coef_shadow[5]);
            for (i = 4; i >= 0; i--)
            begin
                f = clamp48(fx_mul(f, x) + coef_shadow[i]);
                if (i >= 1)
                    fd = clamp48(fx_mul(fd, x) + clamp48(i * coef_shadow[i]));
            end
            if (fd == 0 || math_ov)
            begin
                res.root   = q_t'(x);
                res.status = STATUS_FAILED;
                return res;
            end
            q  = fx_div(f, fd);
            nx = math_ov ? 0 : clamp48(x - q);
            if (math_ov)
            begin
                res.root   = q_t'(x);
                res.status = STATUS_FAILED;
                return res;
            end
            res.root = q_t'(nx);
            qmag     = q < 0 ? -q : q;
            if (qmag < tol_shadow)
            begin
                res.status = STATUS_CONVERGED;
                return res;
            end
            x = nx;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Start-point driver: takes from start_points, predicts at each transfer
    // ---------------------------------------------------------------------
    int send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid && s_tready)
                roots_due.push_back(solve_quintic(s_tdata));
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (start_points.size() > 0 && !calm && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end
            else if (start_points.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= start_points.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor with random back-pressure
    // ---------------------------------------------------------------------
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (roots_due.size() == 0)
                begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    saw_error = 1'b1;
                end
                else
                begin
                    root_result_t want;
                    want = roots_due.pop_front();
                    if (m_tdata[47:0] !== want.root)
                    begin
                        $error("root_estimate: expected %h, got %h", want.root, m_tdata[47:0]);
                        saw_error = 1'b1;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        saw_error = 1'b1;
                    end
                    if (m_tdata[57:48] !== want.steps)
                    begin
                        $error("steps_used: expected %0d, got %0d", want.steps,
                               m_tdata[57:48]);
                        saw_error = 1'b1;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_newton_poly5_root failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Configuration and sequencing
    // ---------------------------------------------------------------------
    // register index lands at byte address 8*idx; idx beyond the list is ignored
    task automatic reg_write(input int idx, input longint value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 6'(idx * 8);
        pwdata  <= 64'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < NCOEF)
            coef_shadow[idx] = longint'($signed(value[47:0]));
        else if (idx == NCOEF)
            tol_shadow = longint'(value[31:0]);
    endtask

    task automatic set_poly(input longint a0, a1, a2, a3, a4, a5, input longint tol);
        reg_write(0, a0);
        reg_write(1, a1);
        reg_write(2, a2);
        reg_write(3, a3);
        reg_write(4, a4);
        reg_write(5, a5);
        reg_write(NCOEF, tol);
    endtask

    // block stays idle from here until the next write; sampled at the falling
    // edge so the driver and monitor updates of the rising edge have settled
    task automatic drain();
        while (start_points.size() > 0 || s_tvalid || roots_due.size() > 0)
            @(negedge clk);
    endtask

    function automatic longint rand48();
        return longint'($signed(48'({$urandom, $urandom})));
    endfunction

    // small value in about +-span, with random fraction bits
    function automatic longint rand_small(input int span);
        return (longint'($urandom_range(0, 2 * span * 65536)) - span * 65536) <<< 16;
    endfunction

    initial
    begin
        longint c[6];
        int     ph, n, j;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        saw_error = 1'b0; calm = 1'b0; cycle_count = 0;
        foreach (coef_shadow[j])
            coef_shadow[j] = 0;
        tol_shadow = 4295;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset coefficients: f' is zero at once
        start_points = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0, 48'h1};
        drain();

        // linear x - 3: two steps; a very negative start saturates f
        set_poly(-3 * ONE, ONE, 0, 0, 0, 0, 4295);
        start_points = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0, 48'hFFFF_FFFF_FFFF,
                         48'(5 * ONE)};
        drain();

        // x^2 - 2: zero derivative at 0, huge quotient near 0, overflow at extremes
        set_poly(-2 * ONE, 0, ONE, 0, 0, 0, 4295);
        start_points = '{48'h0, 48'h1, 48'(ONE), 48'(-3 * ONE), 48'h7FFF_FFFF_FFFF};
        drain();

        // extreme coefficients, widest tolerance; unknown register write ignored
        set_poly(QHI, QLO, QHI, QLO, ONE, QHI, 64'hFFFF_FFFF);
        reg_write(7, 64'h1234_5678);
        start_points = '{48'h0, 48'h1, 48'(ONE)};
        drain();
        set_poly(-ONE, 0, 0, 0, 0, ONE, 64'hFFFF_FFFF);
        start_points = '{48'(2 * ONE), 48'(-2 * ONE)};
        drain();

        // zero tolerance on x^2 + 1: runs the full iteration count
        set_poly(ONE, 0, ONE, 0, 0, 0, 0);
        start_points = '{48'(ONE / 2)};
        drain();

        // random phases: mostly low-degree polynomials with small coefficients
        // and nearby starts, some full-width noise
        for (ph = 0; ph < 5; ph++)
        begin
            for (j = 0; j < 6; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    c[j] = rand48();
                else if (j > 3 && $urandom_range(0, 2) != 0)
                    c[j] = 0;
                else
                    c[j] = rand_small(4);
            end
            calm = (ph == 4);
            set_poly(c[0], c[1], c[2], c[3], c[4], c[5],
                     $urandom_range(0, 3) == 0 ? longint'($urandom)
                                               : longint'($urandom_range(1, 1 << 20)));
            for (n = 0; n < 20; n++)
                start_points.push_back($urandom_range(0, 4) == 0 ? 48'(rand48())
                                                                 : 48'(rand_small(6)));
            drain();
        end

        repeat (200) @(posedge clk);
        if (!saw_error)
            $display("tb_newton_poly5_root passed");
        else
            $display("tb_newton_poly5_root failed");
        $finish;
    end

endmodule

FILE: newton_poly5_root.f
+incdir+hdl
hdl/np5_pkg.sv
hdl/np5_mul.sv
hdl/np5_div.sv
hdl/newton_poly5_root.sv
bench/tb_newton_poly5_root.sv
